[rtl/core/hex8blv_pkg.sv]
// hex8blv_pkg: shared types, constants and helper functions for the hexahedron load-vector block
// no dependencies

package hex8blv_pkg;

    localparam int NODE_DOFS    = 3;
    localparam int FRAC_BITS    = 16;
    localparam int NODES        = 8;
    localparam int CFG_W        = 32;
    localparam int CFG_IDX_W    = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_Z  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DET = 2'd3;

    localparam logic [63:0] GAUSS_Q32 = 64'd2479700524;
    localparam logic [63:0] GAUSS_G   =
        (GAUSS_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic signed [47:0] FORCE_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] FORCE_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic        [19:0] node_number;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } in_item_t;

    typedef struct packed {
        logic        [19:0] out_node;
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
        logic signed [47:0] force_z;
        logic               element_ok;
        logic               last_node;
    } out_item_t;

    // controller to datapath commands
    typedef enum logic [3:0] {
        OP_IDLE   = 4'd0,
        OP_CLEAR  = 4'd1,
        OP_JAC    = 4'd2,
        OP_MIN    = 4'd3,
        OP_DET    = 4'd4,
        OP_CHECK  = 4'd5,
        OP_NL     = 4'd6,
        OP_ACC    = 4'd7,
        OP_MUL    = 4'd8
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] point;
        logic [2:0] node;
        logic [1:0] comp;
        logic [1:0] row;
        logic [3:0] sub;
    } dp_cmd_t;

    typedef struct packed {
        logic det_bad;
    } dp_sts_t;

    // axis sign of corner i along axis a: 1 means plus
    function automatic logic axis_pos(input logic [1:0] a, input logic [2:0] i);
        logic r;
        begin
            case (a)
                2'd0:    r = (i == 3'd1) || (i == 3'd2) || (i == 3'd5) || (i == 3'd6);
                2'd1:    r = (i == 3'd2) || (i == 3'd3) || (i == 3'd6) || (i == 3'd7);
                default: r = i[2];
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [63:0] rnd64(input logic signed [63:0] v,
                                                 input int k);
        logic [63:0] m;
        begin
            m = v[63] ? (64'd0 - v) : v;
            m = (m + (64'd1 << (k - 1))) >> k;
            return v[63] ? $signed(64'd0 - m) : $signed(m);
        end
    endfunction

    // factor along an axis: one + g when corner sign agrees with point sign
    function automatic logic signed [63:0] factor(input logic [1:0] a,
                                                  input logic [2:0] i,
                                                  input logic [2:0] p);
        logic sp;
        begin
            case (a)
                2'd0:    sp = p[2];
                2'd1:    sp = p[1];
                default: sp = p[0];
            endcase
            return (axis_pos(a, i) == sp) ?
                $signed((64'd1 << FRAC_BITS) + GAUSS_G) :
                $signed((64'd1 << FRAC_BITS) - GAUSS_G);
        end
    endfunction

    // shape value of corner i at point p (small constant table)
    function automatic logic signed [31:0] shape_n(input logic [2:0] i, input logic [2:0] p);
        logic signed [63:0] t;
        begin
            t = rnd64(factor(2'd0, i, p) * factor(2'd1, i, p), FRAC_BITS);
            t = rnd64(t * factor(2'd2, i, p), FRAC_BITS + 3);
            return t[31:0];
        end
    endfunction

    // derivative of shape of corner i along natural axis c at point p
    function automatic logic signed [31:0] shape_dn(input logic [1:0] c,
                                                    input logic [2:0] i,
                                                    input logic [2:0] p);
        logic signed [63:0] fa;
        logic signed [63:0] fb;
        logic signed [63:0] t;
        begin
            case (c)
                2'd0:    begin fa = factor(2'd1, i, p); fb = factor(2'd2, i, p); end
                2'd1:    begin fa = factor(2'd0, i, p); fb = factor(2'd2, i, p); end
                default: begin fa = factor(2'd0, i, p); fb = factor(2'd1, i, p); end
            endcase
            t = rnd64(fa * fb, FRAC_BITS + 3);
            return axis_pos(c, i) ? t[31:0] : -t[31:0];
        end
    endfunction

endpackage

[rtl/core/hex8blv_dp.sv]
// hex8blv_dp: datapath with corner store, jacobian, determinant and force accumulators
// depends on hex8blv_pkg

module hex8blv_dp (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [2:0]            wr_slot,
    input  hex8blv_pkg::in_item_t wr_item,
    input  logic [31:0]           load_x,
    input  logic [31:0]           load_y,
    input  logic [31:0]           load_z,
    input  logic [31:0]           min_det,
    input  hex8blv_pkg::dp_cmd_t  cmd,
    output hex8blv_pkg::dp_sts_t  sts,
    input  logic [2:0]            rd_node,
    output logic [19:0]           rd_number,
    output logic signed [47:0]    rd_force [3]
);
    import hex8blv_pkg::*;

    logic signed [31:0] cx_reg [NODES];
    logic signed [31:0] cy_reg [NODES];
    logic signed [31:0] cz_reg [NODES];
    logic        [19:0] num_reg [NODES];
    logic signed [47:0] acc_reg [NODES][3];
    logic signed [63:0] sum_reg;
    logic signed [31:0] jac_reg [3][3];
    logic signed [63:0] m_reg [3];
    logic signed [127:0] s_reg;
    logic        [63:0] det_reg;
    logic signed [63:0] nl_reg;
    logic        [63:0] plo_reg;
    logic               bad_reg;

    logic signed [31:0] coord_sel;
    logic signed [63:0] prod;
    logic signed [63:0] jsum;
    logic signed [63:0] jrnd;
    logic signed [31:0] load_sel;
    logic signed [31:0] jrow_sel;
    logic signed [63:0] m_sel;
    logic signed [32:0] mpart;
    logic signed [64:0] pp;
    logic signed [127:0] term;
    logic signed [127:0] s_abs;
    logic [127:0]        s_rnd;
    logic [31:0]         nl_mag;
    logic [63:0]         phi;
    logic [63:0]         cmag;
    logic [95:0]         cprod;
    logic signed [48:0]  acc_sum;

    // corner store writes
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cx_reg[wr_slot]  <= wr_item.coord_x;
            cy_reg[wr_slot]  <= wr_item.coord_y;
            cz_reg[wr_slot]  <= wr_item.coord_z;
            num_reg[wr_slot] <= wr_item.node_number;
        end
    end

    // jacobian term: one dN * coord product per cycle
    always_comb begin
        case (cmd.row)
            2'd0:    coord_sel = cx_reg[cmd.node];
            2'd1:    coord_sel = cy_reg[cmd.node];
            default: coord_sel = cz_reg[cmd.node];
        endcase
        prod = 64'(shape_dn(cmd.comp, cmd.node, cmd.point)) * 64'(coord_sel);
        jsum = sum_reg + prod;
        jrnd = rnd64(jsum, FRAC_BITS);
    end

    // determinant term, half a minor per cycle, load selection and force contribution
    always_comb begin
        case (cmd.sub[2:1])
            2'd0:    begin jrow_sel = jac_reg[0][0]; m_sel = m_reg[0]; end
            2'd1:    begin jrow_sel = jac_reg[0][1]; m_sel = m_reg[1]; end
            default: begin jrow_sel = jac_reg[0][2]; m_sel = m_reg[2]; end
        endcase
        mpart = cmd.sub[0] ? {m_sel[63], m_sel[63:32]} : {1'b0, m_sel[31:0]};
        pp    = jrow_sel * mpart;
        term  = cmd.sub[0] ? (128'(pp) <<< 32) : 128'(pp);
        if (cmd.sub[2:1] == 2'd1) term = -term;
        s_abs = s_reg[127] ? -s_reg : s_reg;
        s_rnd = s_abs + 128'h8000_0000;
        case (cmd.comp)
            2'd0:    load_sel = load_x;
            2'd1:    load_sel = load_y;
            default: load_sel = load_z;
        endcase
        // |N * load| stays below 2^31, so 32 bits carry the magnitude
        nl_mag = nl_reg[63] ? 32'(64'd0 - nl_reg) : nl_reg[31:0];
        phi    = nl_mag * det_reg[63:32];
        cprod  = {phi, 32'd0} + {32'd0, plo_reg};
        if (cprod[95:63] != '0) cmag = 64'd1 << 47;
        else                    cmag = 64'((cprod[63:0] + 64'h8000) >> 16);
        if (cmag > (64'd1 << 47)) cmag = 64'd1 << 47;
        acc_sum = 49'(acc_reg[cmd.node][cmd.comp]) +
                  (nl_reg[63] ? -$signed({1'b0, cmag[47:0]}) : $signed({1'b0, cmag[47:0]}));
    end

    // sequenced datapath operations
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_CLEAR: begin
                for (int i = 0; i < NODES; i++)
                    for (int c = 0; c < 3; c++) acc_reg[i][c] <= '0;
                bad_reg <= 1'b0;
                sum_reg <= '0;
            end
            OP_JAC: begin
                if (cmd.node == 3'd7) begin
                    jac_reg[cmd.row][cmd.comp] <= (jrnd > 64'sd2147483647) ? 32'h7FFF_FFFF :
                        (jrnd < -64'sd2147483648) ? 32'h8000_0000 : jrnd[31:0];
                    sum_reg <= '0;
                end else begin
                    sum_reg <= jsum;
                end
            end
            OP_MIN: begin
                case (cmd.sub[1:0])
                    2'd0: m_reg[0] <= 64'(jac_reg[1][1]) * 64'(jac_reg[2][2])
                                    - 64'(jac_reg[1][2]) * 64'(jac_reg[2][1]);
                    2'd1: m_reg[1] <= 64'(jac_reg[1][0]) * 64'(jac_reg[2][2])
                                    - 64'(jac_reg[1][2]) * 64'(jac_reg[2][0]);
                    default: m_reg[2] <= 64'(jac_reg[1][0]) * 64'(jac_reg[2][1])
                                    - 64'(jac_reg[1][1]) * 64'(jac_reg[2][0]);
                endcase
                s_reg <= '0;
            end
            OP_DET: begin
                s_reg <= s_reg + term;
            end
            OP_CHECK: begin
                det_reg <= s_rnd[95:32];
                if (s_rnd[95:32] <= 64'(min_det)) bad_reg <= 1'b1;
            end
            OP_NL: begin
                nl_reg <= rnd64(64'(shape_n(cmd.node, cmd.point)) * 64'(load_sel), FRAC_BITS);
            end
            OP_MUL: begin
                plo_reg <= nl_mag * det_reg[31:0];
            end
            OP_ACC: begin
                if (acc_sum > 49'(FORCE_MAX))      acc_reg[cmd.node][cmd.comp] <= FORCE_MAX;
                else if (acc_sum < 49'(FORCE_MIN)) acc_reg[cmd.node][cmd.comp] <= FORCE_MIN;
                else acc_reg[cmd.node][cmd.comp] <= acc_sum[47:0];
            end
            default: ;
        endcase
    end

    assign sts.det_bad = bad_reg;
    assign rd_number   = num_reg[rd_node];
    assign rd_force[0] = acc_reg[rd_node][0];
    assign rd_force[1] = (NODE_DOFS > 1) ? acc_reg[rd_node][1] : '0;
    assign rd_force[2] = (NODE_DOFS > 2) ? acc_reg[rd_node][2] : '0;

endmodule

[rtl/core/hex8blv_ctrl.sv]
// hex8blv_ctrl: controller state machine sequencing load, quadrature and output
// depends on hex8blv_pkg

module hex8blv_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic [2:0]           wr_slot,
    output hex8blv_pkg::dp_cmd_t cmd,
    input  hex8blv_pkg::dp_sts_t sts,
    output logic                 o_valid,
    input  logic                 o_ready,
    output logic [2:0]           o_node,
    output logic                 o_ok
);
    import hex8blv_pkg::*;

    typedef enum logic [7:0] {
        ST_LOAD  = 8'b0000_0001,
        ST_CLEAR = 8'b0000_0010,
        ST_JAC   = 8'b0000_0100,
        ST_MIN   = 8'b0000_1000,
        ST_DET   = 8'b0001_0000,
        ST_CHECK = 8'b0010_0000,
        ST_ACC   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [2:0] point_reg, point_next;
    logic [2:0] node_reg, node_next;
    logic [1:0] comp_reg, comp_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] ph_reg, ph_next;

    assign s_ready = (state_reg == ST_LOAD);
    assign wr_slot = cnt_reg[2:0];
    assign o_valid = (state_reg == ST_OUT);
    assign o_node  = node_reg;
    assign o_ok    = !sts.det_bad;

    // command decode
    always_comb begin
        cmd.point = point_reg;
        cmd.node  = node_reg;
        cmd.comp  = comp_reg;
        cmd.row   = row_reg;
        cmd.sub   = cnt_reg;
        case (state_reg)
            ST_CLEAR: cmd.op = OP_CLEAR;
            ST_JAC:   cmd.op = OP_JAC;
            ST_MIN:   cmd.op = OP_MIN;
            ST_DET:   cmd.op = OP_DET;
            ST_CHECK: cmd.op = OP_CHECK;
            ST_ACC: begin
                case (ph_reg)
                    2'd0:    cmd.op = OP_NL;
                    2'd1:    cmd.op = OP_MUL;
                    default: cmd.op = OP_ACC;
                endcase
            end
            default:  cmd.op = OP_IDLE;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        point_next = point_reg;
        node_next  = node_reg;
        comp_next  = comp_reg;
        row_next   = row_reg;
        ph_next    = ph_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd7) begin
                        cnt_next   = '0;
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR: begin
                point_next = '0; node_next = '0; comp_next = '0; row_next = '0;
                state_next = ST_JAC;
            end
            ST_JAC: begin
                node_next = node_reg + 3'd1;
                if (node_reg == 3'd7) begin
                    if (comp_reg == 2'd2) begin
                        comp_next = '0;
                        if (row_reg == 2'd2) begin
                            row_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_MIN;
                        end else row_next = row_reg + 2'd1;
                    end else comp_next = comp_reg + 2'd1;
                end
            end
            ST_MIN: begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd2) begin cnt_next = '0; state_next = ST_DET; end
            end
            // two half products per minor
            ST_DET: begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd5) begin cnt_next = '0; state_next = ST_CHECK; end
            end
            ST_CHECK: begin
                node_next = '0; comp_next = '0; ph_next = '0;
                state_next = ST_ACC;
            end
            // per node and component: load product, low half, high half and add; a rejected element goes to output
            ST_ACC: begin
                if (sts.det_bad) begin
                    node_next  = '0;
                    state_next = ST_OUT;
                end else if (ph_reg != 2'd2) begin
                    ph_next = ph_reg + 2'd1;
                end else begin
                    ph_next = '0;
                    if (comp_reg == 2'(NODE_DOFS - 1)) begin
                        comp_next = '0;
                        node_next = node_reg + 3'd1;
                        if (node_reg == 3'd7) begin
                            if (point_reg == 3'd7) state_next = ST_OUT;
                            else begin
                                point_next = point_reg + 3'd1;
                                state_next = ST_JAC;
                            end
                        end
                    end else comp_next = comp_reg + 2'd1;
                end
            end
            ST_OUT: begin
                if (o_ready) begin
                    node_next = node_reg + 3'd1;
                    if (node_reg == 3'd7) state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            point_reg <= '0;
            node_reg  <= '0;
            comp_reg  <= '0;
            row_reg   <= '0;
            ph_reg    <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            point_reg <= point_next;
            node_reg  <= node_next;
            comp_reg  <= comp_next;
            row_reg   <= row_next;
            ph_reg    <= ph_next;
        end
    end

endmodule

[rtl/core/hex8_body_load_vector.sv]
// hex8_body_load_vector: top level of the hexahedron body-force load vector
// sequence after the eighth corner item: a clear, then per gauss point the jacobian terms,
// the minors, the determinant halves, the check and the force steps; a rejected element stops early
// a new element is taken only after the last result of the previous one is accepted;
// aresetn (synchronous, active low) clears control, config
// depends on hex8blv_pkg, hex8blv_ctrl, hex8blv_dp

module hex8_body_load_vector (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  hex8blv_pkg::in_item_t  s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output hex8blv_pkg::out_item_t m_data,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data
);
    import hex8blv_pkg::*;

    logic [31:0]        load_x_reg, load_y_reg, load_z_reg, min_det_reg;
    logic [2:0]         wr_slot;
    dp_cmd_t            cmd;
    dp_sts_t            sts;
    logic [2:0]         o_node;
    logic               o_ok;
    logic [19:0]        rd_number;
    logic signed [47:0] rd_force [3];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_x_reg  <= '0;
            load_y_reg  <= '0;
            load_z_reg  <= '0;
            min_det_reg <= 32'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LOAD_X:  load_x_reg  <= cfg_data;
                REG_LOAD_Y:  load_y_reg  <= cfg_data;
                REG_LOAD_Z:  load_z_reg  <= cfg_data;
                REG_MIN_DET: min_det_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    hex8blv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .wr_slot (wr_slot),
        .cmd     (cmd),
        .sts     (sts),
        .o_valid (m_valid),
        .o_ready (m_ready),
        .o_node  (o_node),
        .o_ok    (o_ok)
    );

    hex8blv_dp u_dp (
        .aclk      (aclk),
        .wr_en     (s_valid && s_ready),
        .wr_slot   (wr_slot),
        .wr_item   (s_data),
        .load_x    (load_x_reg),
        .load_y    (load_y_reg),
        .load_z    (load_z_reg),
        .min_det   (min_det_reg),
        .cmd       (cmd),
        .sts       (sts),
        .rd_node   (o_node),
        .rd_number (rd_number),
        .rd_force  (rd_force)
    );

    // result item assembly, rejected elements carry zero forces
    always_comb begin
        m_data.out_node   = rd_number;
        m_data.force_x    = o_ok ? rd_force[0] : '0;
        m_data.force_y    = o_ok ? rd_force[1] : '0;
        m_data.force_z    = o_ok ? rd_force[2] : '0;
        m_data.element_ok = o_ok;
        m_data.last_node  = (o_node == 3'd7);
    end

endmodule

[rtl/core/hex8blv_chk.sv]
// hex8blv_chk: port-level checker for the load-vector block, bound to the top level
// depends on hex8blv_pkg

module hex8blv_chk (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input hex8blv_pkg::out_item_t m_data
);
    import hex8blv_pkg::*;

    // no input taken while results are offered
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input ready during output");

    // rejected element carries zero forces
    a_zero_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.element_ok) |->
        (m_data.force_x == '0 && m_data.force_y == '0 && m_data.force_z == '0))
        else $error("rejected element with forces");

    // after last item the block returns to loading
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_node) |=> !m_valid)
        else $error("output continued after last item");

    // valid holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("output valid dropped");

endmodule

bind hex8_body_load_vector hex8blv_chk u_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[sim/hex8blv_checker.sv]
// hex8blv_checker: predicts and checks the nodal force items of hex8_body_load_vector
// watches the input, result and register ports; depends on hex8blv_pkg

module hex8blv_checker (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  hex8blv_pkg::in_item_t  s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  hex8blv_pkg::out_item_t m_data,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    output int                     fail_count,
    output int                     forces_pending
);
    import hex8blv_pkg::*;

    localparam longint unsigned CONTRIB_CAP = 64'd1 << 47;

    logic [31:0]   regs [4];
    in_item_t      corners [8];
    int            corner_cnt;
    longint        node_force [24];
    out_item_t     expected_forces [$];

    // divide by 2^k, rounding half away from zero
    function automatic longint round_shift(input longint v, input int k);
        longint unsigned m;
        begin
            m = (v < 0) ? longint'(-v) : longint'(v);
            m = (m + (64'd1 << (k - 1))) >> k;
            return (v < 0) ? -$signed(m) : $signed(m);
        end
    endfunction

    function automatic longint clamp32(input longint v);
        begin
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        end
    endfunction

    function automatic int corner_sign(input int a, input int i);
        logic pos;
        begin
            case (a)
                0:       pos = (i == 1) || (i == 2) || (i == 5) || (i == 6);
                1:       pos = (i == 2) || (i == 3) || (i == 6) || (i == 7);
                default: pos = (i >= 4);
            endcase
            return pos ? 1 : -1;
        end
    endfunction

    // abs of the 3x3 determinant, rounded to Q16.16
    function automatic longint unsigned jac_det(input longint j [3][3]);
        logic signed [127:0] m0, m1, m2, a0, a1, a2, s;
        logic        [127:0] u;
        begin
            m0 = j[1][1] * j[2][2] - j[1][2] * j[2][1];
            m1 = j[1][0] * j[2][2] - j[1][2] * j[2][0];
            m2 = j[1][0] * j[2][1] - j[1][1] * j[2][0];
            a0 = j[0][0];
            a1 = j[0][1];
            a2 = j[0][2];
            s  = a0 * m0 - a1 * m1 + a2 * m2;
            if (s < 0) s = -s;
            u = s + (128'd1 << 31);
            return u[95:32];
        end
    endfunction

    function automatic void add_force(input int idx, input longint nl,
                                      input longint unsigned det);
        longint unsigned m, c;
        longint v;
        begin
            m = (nl < 0) ? longint'(-nl) : longint'(nl);
            if (m != 0 && det > 64'h7FFF_FFFF_FFFF_FFFF / m) c = CONTRIB_CAP;
            else c = (m * det + 64'h8000) >> 16;
            if (c > CONTRIB_CAP) c = CONTRIB_CAP;
            v = node_force[idx] + ((nl < 0) ? -$signed(c) : $signed(c));
            if (v > longint'(FORCE_MAX)) v = FORCE_MAX;
            if (v < longint'(FORCE_MIN)) v = FORCE_MIN;
            node_force[idx] = v;
        end
    endfunction

    // gauss quadrature over the stored corners; 0 when the element is rejected
    function automatic logic integrate_element();
        longint one, g, nv [8], dn [3][8], jac [3][3], f [3], s;
        longint unsigned det;
        int sp [3];
        begin
            one = 64'sd1 << FRAC_BITS;
            g   = (64'd2479700524 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
            for (int k = 0; k < 24; k++) node_force[k] = 0;
            for (int p = 0; p < 8; p++) begin
                sp[0] = p[2] ? 1 : -1;
                sp[1] = p[1] ? 1 : -1;
                sp[2] = p[0] ? 1 : -1;
                for (int i = 0; i < 8; i++) begin
                    for (int a = 0; a < 3; a++)
                        f[a] = (corner_sign(a, i) == sp[a]) ? one + g : one - g;
                    nv[i] = round_shift(round_shift(f[0] * f[1], FRAC_BITS) * f[2],
                                        FRAC_BITS + 3);
                    dn[0][i] = corner_sign(0, i) * round_shift(f[1] * f[2], FRAC_BITS + 3);
                    dn[1][i] = corner_sign(1, i) * round_shift(f[0] * f[2], FRAC_BITS + 3);
                    dn[2][i] = corner_sign(2, i) * round_shift(f[0] * f[1], FRAC_BITS + 3);
                end
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        s = 0;
                        for (int i = 0; i < 8; i++) begin
                            case (r)
                                0:       s += dn[c][i] * longint'(corners[i].coord_x);
                                1:       s += dn[c][i] * longint'(corners[i].coord_y);
                                default: s += dn[c][i] * longint'(corners[i].coord_z);
                            endcase
                        end
                        jac[r][c] = clamp32(round_shift(s, FRAC_BITS));
                    end
                end
                det = jac_det(jac);
                if (det <= {32'd0, regs[REG_MIN_DET]}) begin
                    for (int k = 0; k < 24; k++) node_force[k] = 0;
                    return 1'b0;
                end
                for (int i = 0; i < 8; i++)
                    for (int c = 0; c < NODE_DOFS && c < 3; c++)
                        add_force(i * 3 + c,
                                  round_shift(nv[i] * longint'($signed(regs[c])), FRAC_BITS),
                                  det);
            end
            return 1'b1;
        end
    endfunction

    // register writes, corner collection and result comparison
    always @(posedge aclk) begin
        out_item_t exp_item;
        logic      ok;
        if (!aresetn) begin
            regs[REG_LOAD_X]  = '0;
            regs[REG_LOAD_Y]  = '0;
            regs[REG_LOAD_Z]  = '0;
            regs[REG_MIN_DET] = 32'd1;
            corner_cnt = 0;
            fail_count = 0;
            expected_forces.delete();
        end else begin
            if (cfg_we) regs[cfg_index] = cfg_data;
            if (s_valid && s_ready) begin
                corners[corner_cnt] = s_data;
                corner_cnt++;
                if (corner_cnt == 8) begin
                    corner_cnt = 0;
                    ok = integrate_element();
                    for (int i = 0; i < 8; i++) begin
                        exp_item.out_node   = corners[i].node_number;
                        exp_item.force_x    = node_force[i * 3][47:0];
                        exp_item.force_y    = node_force[i * 3 + 1][47:0];
                        exp_item.force_z    = node_force[i * 3 + 2][47:0];
                        exp_item.element_ok = ok;
                        exp_item.last_node  = (i == 7);
                        expected_forces.insert(expected_forces.size(), exp_item);
                    end
                end
            end
            if (m_valid && m_ready) begin
                if (expected_forces.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected force item: %p", m_data);
                end else begin
                    exp_item = expected_forces.pop_front();
                    if (m_data.out_node !== exp_item.out_node ||
                        m_data.force_x !== exp_item.force_x ||
                        m_data.force_y !== exp_item.force_y ||
                        m_data.force_z !== exp_item.force_z ||
                        m_data.element_ok !== exp_item.element_ok ||
                        m_data.last_node !== exp_item.last_node) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("force mismatch: expected %p, got %p",
                                     exp_item, m_data);
                    end
                end
            end
        end
        forces_pending <= expected_forces.size();
    end

endmodule

[sim/tb_hex8_body_load_vector.sv]
// tb_hex8_body_load_vector: stimulus and verdict for hex8_body_load_vector
// depends on hex8blv_pkg, hex8_body_load_vector and hex8blv_checker

module tb_hex8_body_load_vector;
    import hex8blv_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;
    logic      cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_LOAD_X;
    logic [31:0] cfg_data = '0;
    int  fail_count;
    int  forces_pending;
    bit  idle_on = 1'b1;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    int  quiet_cycles = 0;

    hex8_body_load_vector DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    hex8blv_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .forces_pending(forces_pending)
    );

    always #2 aclk = ~aclk;

    // result side: random stalls while idle_on is set, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            m_ready <= 1'b0;
            repeat (3000) @(posedge aclk);
            hold_done = 1'b1;
        end else begin
            m_ready <= !idle_on || ($urandom_range(0, 99) >= 24);
        end
    end

    // stall watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_corner(input logic [19:0] node, input logic [31:0] x,
                               input logic [31:0] y, input logic [31:0] z);
        if (idle_on && $urandom_range(0, 99) < 24) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{node_number: node, coord_x: x, coord_y: y, coord_z: z};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [19:0] pick_node();
        case ($urandom_range(0, 9))
            0:       return 20'h00000;
            1:       return 20'hFFFFF;
            default: return 20'($urandom());
        endcase
    endfunction

    // kinds: 0 brick with jitter, 1 noise, 2 flat in z, 3 full-range cube
    task automatic send_element(input int kind);
        int ox, oy, oz, hx, hy, hz, jit, x, y, z;
        ox  = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
        oy  = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
        oz  = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
        hx  = $urandom_range(32'h1000, 32'h40_0000);
        hy  = $urandom_range(32'h1000, 32'h40_0000);
        hz  = (kind == 2) ? 0 : $urandom_range(32'h1000, 32'h40_0000);
        for (int i = 0; i < 8; i++) begin
            jit = hx / 16;
            x = ox + (((i == 1) || (i == 2) || (i == 5) || (i == 6)) ? hx : -hx)
                   + $urandom_range(0, jit) - jit / 2;
            y = oy + (((i == 2) || (i == 3) || (i >= 6)) ? hy : -hy)
                   + $urandom_range(0, jit) - jit / 2;
            z = oz + ((i >= 4) ? hz : -hz);
            if (kind == 1) begin
                x = $urandom();
                y = $urandom();
                z = $urandom();
            end else if (kind == 3) begin
                x = ((i == 1) || (i == 2) || (i == 5) || (i == 6)) ? 32'h7FFF_FFFF
                                                                   : 32'h8000_0000;
                y = ((i == 2) || (i == 3) || (i >= 6)) ? 32'h7FFF_FFFF : 32'h8000_0000;
                z = (i >= 4) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end
            send_corner(pick_node(), x, y, z);
        end
    endtask

    // the count of pending items is registered, so it is let catch up before it is polled
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (forces_pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    initial begin
        int r;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed elements with full positive x load and full negative y load
        write_reg(REG_LOAD_X, 32'h7FFF_FFFF);
        write_reg(REG_LOAD_Y, 32'h8000_0000);
        write_reg(REG_LOAD_Z, 32'h0001_0000);
        write_reg(REG_MIN_DET, 32'd1);
        send_element(3);
        send_element(0);
        send_element(2);
        wait_idle();

        for (int phase = 1; phase <= 5; phase++) begin
            case (phase)
                1: begin
                    write_reg(REG_LOAD_X, $urandom());
                    write_reg(REG_LOAD_Y, $urandom());
                    write_reg(REG_LOAD_Z, $urandom());
                    write_reg(REG_MIN_DET, 32'd1);
                end
                2: begin
                    write_reg(REG_LOAD_X, 32'h7FFF_FFFF);
                    write_reg(REG_LOAD_Y, 32'h7FFF_FFFF);
                    write_reg(REG_LOAD_Z, 32'h7FFF_FFFF);
                    write_reg(REG_MIN_DET, 32'd0);
                    hold_req = 1'b1;
                end
                3: begin
                    write_reg(REG_LOAD_X, 32'h8000_0000);
                    write_reg(REG_LOAD_Y, 32'h8000_0000);
                    write_reg(REG_LOAD_Z, 32'h0000_0000);
                    write_reg(REG_MIN_DET, $urandom_range(0, 32'h1_0000));
                    idle_on = 1'b0;
                end
                4: begin
                    write_reg(REG_LOAD_X, $urandom());
                    write_reg(REG_LOAD_Y, $urandom());
                    write_reg(REG_LOAD_Z, $urandom());
                    write_reg(REG_MIN_DET, 32'hFFFF_FFFF);
                    idle_on = 1'b1;
                end
                default: begin
                    write_reg(REG_LOAD_X, $urandom());
                    write_reg(REG_LOAD_Y, $urandom());
                    write_reg(REG_LOAD_Z, $urandom());
                    write_reg(REG_MIN_DET, $urandom_range(0, 32'hFFFF));
                end
            endcase
            for (int e = 0; e < 12; e++) begin
                r = $urandom_range(0, 99);
                if (r < 75)      send_element(0);
                else if (r < 87) send_element(1);
                else if (r < 95) send_element(2);
                else             send_element(3);
            end
            wait_idle();
        end

        if (fail_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/hex8blv_pkg.sv
rtl/core/hex8blv_dp.sv
rtl/core/hex8blv_ctrl.sv
rtl/core/hex8_body_load_vector.sv
rtl/core/hex8blv_chk.sv
sim/hex8blv_checker.sv
sim/tb_hex8_body_load_vector.sv
